// ----- hdl/dnci_pkg.sv -----
// ---------------------------------------------------------------------------
// dnci_pkg
// shared constants and waypoint tables of the day/night color interpolator
// ---------------------------------------------------------------------------
package dnci_pkg;

   localparam int WP_COUNT = 13;

   // configuration register indexes
   localparam logic CSR_CYCLE_PERIOD      = 1'b0;
   localparam logic CSR_MASTER_BRIGHTNESS = 1'b1;

   localparam logic [26:0] PERIOD_RESET     = 27'd60000;
   localparam logic [7:0]  BRIGHTNESS_RESET = 8'd255;

   // reciprocal of 100 for products below 2^16
   localparam logic [12:0] RECIP_100       = 13'd5243;
   localparam int          RECIP_100_SHIFT = 19;

   typedef logic [3:0] seg_type;

   localparam logic [15:0] WP_POS [WP_COUNT] = '{
      16'd0, 16'd5243, 16'd9175, 16'd14418, 16'd19661, 16'd24904, 16'd32768,
      16'd40632, 16'd45875, 16'd51118, 16'd56361, 16'd60293, 16'd65535};
   localparam logic [7:0] WP_RED [WP_COUNT] = '{
      8'd10, 8'd10, 8'd30, 8'd200, 8'd240, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd235, 8'd180, 8'd40, 8'd10};
   localparam logic [7:0] WP_GREEN [WP_COUNT] = '{
      8'd15, 8'd15, 8'd25, 8'd80, 8'd140, 8'd210, 8'd245,
      8'd245, 8'd200, 8'd110, 8'd70, 8'd30, 8'd15};
   localparam logic [7:0] WP_BLUE [WP_COUNT] = '{
      8'd60, 8'd60, 8'd80, 8'd60, 8'd70, 8'd160, 8'd220,
      8'd220, 8'd150, 8'd50, 8'd90, 8'd90, 8'd60};
   localparam logic [7:0] WP_PCT [WP_COUNT] = '{
      8'd20, 8'd20, 8'd28, 8'd55, 8'd80, 8'd95, 8'd100,
      8'd100, 8'd92, 8'd75, 8'd45, 8'd28, 8'd20};

endpackage

// ----- hdl/dnci_pos_mod.sv -----
// ---------------------------------------------------------------------------
// dnci_pos_mod
// elapsed time modulo the period, one remainder bit per stage
// ---------------------------------------------------------------------------
module dnci_pos_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic [26:0] period,
   input  logic        in_valid,
   input  logic [31:0] in_elapsed,
   output logic        out_valid,
   output logic [26:0] out_pos
);
   import dnci_pkg::*;

   logic        src_v   [32];
   logic [26:0] src_rem [32];
   logic [31:0] src_el  [32];
   logic        v_ff    [32];
   logic [26:0] rem_ff  [32];
   logic [31:0] el_ff   [32];
   logic [26:0] rem_in  [32];

   assign src_v[0]   = in_valid;
   assign src_rem[0] = '0;
   assign src_el[0]  = in_elapsed;

   for (genvar s = 0; s < 32; s++) begin : g_stage
      logic [27:0] trial;
      if (s > 0) begin : g_link
         assign src_v[s]   = v_ff[s-1];
         assign src_rem[s] = rem_ff[s-1];
         assign src_el[s]  = el_ff[s-1];
      end
      always_comb begin
         trial = {src_rem[s], src_el[s][31-s]};
         if (trial >= {1'b0, period}) begin
            rem_in[s] = 27'(trial - {1'b0, period});
         end else begin
            rem_in[s] = trial[26:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= src_v[s];
         end
         if (adv) begin
            rem_ff[s] <= rem_in[s];
            el_ff[s]  <= src_el[s];
         end
      end
   end

   assign out_valid = v_ff[31];
   assign out_pos   = rem_ff[31];
endmodule

// ----- hdl/dnci_prog_div.sv -----
// ---------------------------------------------------------------------------
// dnci_prog_div
// progress = pos * 65536 / period, one quotient bit per stage
// ---------------------------------------------------------------------------
module dnci_prog_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic [26:0] period,
   input  logic        in_valid,
   input  logic [26:0] in_pos,
   output logic        out_valid,
   output logic [15:0] out_progress
);
   import dnci_pkg::*;

   logic        src_v [16];
   logic [26:0] src_r [16];
   logic [15:0] src_q [16];
   logic        v_ff  [16];
   logic [26:0] r_ff  [16];
   logic [15:0] q_ff  [16];

   assign src_v[0] = in_valid;
   assign src_r[0] = in_pos;
   assign src_q[0] = '0;

   for (genvar s = 0; s < 16; s++) begin : g_stage
      logic [27:0] trial;
      logic        ge;
      logic [26:0] r_in;
      if (s > 0) begin : g_link
         assign src_v[s] = v_ff[s-1];
         assign src_r[s] = r_ff[s-1];
         assign src_q[s] = q_ff[s-1];
      end
      always_comb begin
         trial = {src_r[s], 1'b0};
         ge    = trial >= {1'b0, period};
         if (ge) begin
            r_in = 27'(trial - {1'b0, period});
         end else begin
            r_in = trial[26:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= src_v[s];
         end
         if (adv) begin
            r_ff[s] <= r_in;
            q_ff[s] <= {src_q[s][14:0], ge};
         end
      end
   end

   assign out_valid    = v_ff[15];
   assign out_progress = q_ff[15];
endmodule

// ----- hdl/dnci_seg_frac.sv -----
// ---------------------------------------------------------------------------
// dnci_seg_frac
// segment lookup, then segment progress 0..256 by a nine-stage divider
// ---------------------------------------------------------------------------
module dnci_seg_frac (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [15:0]         in_progress,
   output logic                out_valid,
   output dnci_pkg::seg_type   out_seg,
   output logic [8:0]          out_frac
);
   import dnci_pkg::*;

   seg_type     seg_in;
   logic [12:0] diff_in;
   logic [12:0] span_in;
   logic        a_v_ff;
   seg_type     a_seg_ff;
   logic [12:0] a_diff_ff;
   logic [12:0] a_span_ff;

   // first waypoint above the progress, else the final segment
   always_comb begin
      seg_in = seg_type'(WP_COUNT - 2);
      for (int i = WP_COUNT - 2; i >= 1; i--) begin
         if (in_progress < WP_POS[i]) begin
            seg_in = seg_type'(i - 1);
         end
      end
      diff_in = 13'(in_progress - WP_POS[seg_in]);
      span_in = 13'(WP_POS[seg_in + 4'd1] - WP_POS[seg_in]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= in_valid;
      end
      if (adv) begin
         a_seg_ff  <= seg_in;
         a_diff_ff <= diff_in;
         a_span_ff <= span_in;
      end
   end

   logic        src_v    [9];
   seg_type     src_seg  [9];
   logic [12:0] src_r    [9];
   logic [12:0] src_span [9];
   logic [8:0]  src_q    [9];
   logic        v_ff     [9];
   seg_type     seg_ff   [9];
   logic [12:0] r_ff     [9];
   logic [12:0] span_ff  [9];
   logic [8:0]  q_ff     [9];

   assign src_v[0]    = a_v_ff;
   assign src_seg[0]  = a_seg_ff;
   assign src_r[0]    = a_diff_ff;
   assign src_span[0] = a_span_ff;
   assign src_q[0]    = '0;

   for (genvar s = 0; s < 9; s++) begin : g_stage
      logic [13:0] trial;
      logic        ge;
      logic [12:0] r_in;
      if (s > 0) begin : g_link
         assign src_v[s]    = v_ff[s-1];
         assign src_seg[s]  = seg_ff[s-1];
         assign src_r[s]    = r_ff[s-1];
         assign src_span[s] = span_ff[s-1];
         assign src_q[s]    = q_ff[s-1];
      end
      always_comb begin
         // top quotient bit compares without a shift so diff == span gives 256
         if (s == 0) begin
            trial = {1'b0, src_r[s]};
         end else begin
            trial = {src_r[s], 1'b0};
         end
         ge = trial >= {1'b0, src_span[s]};
         if (ge) begin
            r_in = 13'(trial - {1'b0, src_span[s]});
         end else begin
            r_in = trial[12:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= src_v[s];
         end
         if (adv) begin
            seg_ff[s]  <= src_seg[s];
            r_ff[s]    <= r_in;
            span_ff[s] <= src_span[s];
            q_ff[s]    <= {src_q[s][7:0], ge};
         end
      end
   end

   assign out_valid = v_ff[8];
   assign out_seg   = seg_ff[8];
   assign out_frac  = q_ff[8];
endmodule

// ----- hdl/dnci_blend.sv -----
// ---------------------------------------------------------------------------
// dnci_blend
// linear blend of color and percent, then brightness scaling by pct / 100
// ---------------------------------------------------------------------------
module dnci_blend (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [7:0]        master,
   input  logic              in_valid,
   input  dnci_pkg::seg_type in_seg,
   input  logic [8:0]        in_frac,
   output logic              out_valid,
   output logic [7:0]        out_red,
   output logic [7:0]        out_green,
   output logic [7:0]        out_blue,
   output logic [7:0]        out_bright
);
   import dnci_pkg::*;

   // channels: red, green, blue, percent
   logic [7:0]         from_in [4];
   logic [7:0]         to_in   [4];
   logic signed [19:0] prod_in [4];
   logic               p_v_ff;
   logic [7:0]         from_ff [4];
   logic signed [19:0] prod_ff [4];

   always_comb begin
      from_in[0] = WP_RED[in_seg];
      from_in[1] = WP_GREEN[in_seg];
      from_in[2] = WP_BLUE[in_seg];
      from_in[3] = WP_PCT[in_seg];
      to_in[0]   = WP_RED[in_seg + 4'd1];
      to_in[1]   = WP_GREEN[in_seg + 4'd1];
      to_in[2]   = WP_BLUE[in_seg + 4'd1];
      to_in[3]   = WP_PCT[in_seg + 4'd1];
      for (int c = 0; c < 4; c++) begin
         prod_in[c] = ($signed({12'b0, to_in[c]}) - $signed({12'b0, from_in[c]}))
                    * $signed({11'b0, in_frac});
      end
   end

   logic signed [19:0] adj     [4];
   logic [7:0]         lvl_in  [4];
   logic               l_v_ff;
   logic [7:0]         lvl_ff  [3];
   logic [15:0]        bprod_ff;
   logic [15:0]        bprod_in;

   // divide by 256 with truncation toward zero
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         adj[c]    = prod_ff[c] + (prod_ff[c][19] ? 20'sd255 : 20'sd0);
         lvl_in[c] = from_ff[c] + 8'(adj[c] >>> 8);
      end
      bprod_in = {8'b0, master} * {8'b0, lvl_in[3]};
   end

   logic [28:0] scaled;
   logic        o_v_ff;
   logic [7:0]  o_lvl_ff [3];
   logic [7:0]  o_bright_ff;

   assign scaled = {13'b0, bprod_ff} * {16'b0, RECIP_100};

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         l_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (adv) begin
         p_v_ff <= in_valid;
         l_v_ff <= p_v_ff;
         o_v_ff <= l_v_ff;
      end
      if (adv) begin
         for (int c = 0; c < 4; c++) begin
            from_ff[c] <= from_in[c];
            prod_ff[c] <= prod_in[c];
         end
         for (int c = 0; c < 3; c++) begin
            lvl_ff[c]   <= lvl_in[c];
            o_lvl_ff[c] <= lvl_ff[c];
         end
         bprod_ff    <= bprod_in;
         o_bright_ff <= scaled[RECIP_100_SHIFT +: 8];
      end
   end

   assign out_valid  = o_v_ff;
   assign out_red    = o_lvl_ff[0];
   assign out_green  = o_lvl_ff[1];
   assign out_blue   = o_lvl_ff[2];
   assign out_bright = o_bright_ff;
endmodule

// ----- hdl/day_night_color_interpolator_top.sv -----
// ---------------------------------------------------------------------------
// day_night_color_interpolator_top
// time of day to interpolated color and brightness, fully pipelined
// ---------------------------------------------------------------------------
//  channel | ports                         | transaction
//  req     | req_valid / req_stall         | one elapsed time in ms
//  rsp     | rsp_valid / rsp_stall         | rgb levels and effective brightness
//  csr     | csr_write_enable, index, data | one register write
//
//  one transaction per cycle enters while req_stall is low; the path is 62 register stages, output included
//  the depth comes from the 32-stage modulo pipe, the 16-stage progress divider,
//  the segment lookup plus 9-stage fraction divider, and 3 blend stages
//  reset (synchronous, active high) empties the pipe and restores the registers
//  a held rsp lets one more transaction land in a skid register, then req stalls
// ---------------------------------------------------------------------------
module day_night_color_interpolator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_elapsed_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_level,
   output logic [7:0]  rsp_green_level,
   output logic [7:0]  rsp_blue_level,
   output logic [7:0]  rsp_effective_brightness,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [26:0] csr_data
);
   import dnci_pkg::*;

   // configuration registers
   logic [26:0] period_ff;
   logic [7:0]  master_ff;
   logic [26:0] period_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         master_ff <= BRIGHTNESS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CYCLE_PERIOD:      period_ff <= csr_data;
            CSR_MASTER_BRIGHTNESS: master_ff <= csr_data[7:0];
            default:               period_ff <= period_ff;
         endcase
      end
   end

   // a zero period behaves as one
   assign period_eff = (period_ff == '0) ? 27'd1 : period_ff;

   // whole pipe advances together unless the skid register is holding
   logic adv;
   logic skid_v_ff;
   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   logic        pos_v;
   logic [26:0] pos;
   logic        prog_v;
   logic [15:0] progress;
   logic        frac_v;
   seg_type     seg;
   logic [8:0]  frac;
   logic        p_v;
   logic [7:0]  p_red, p_green, p_blue, p_bright;

   dnci_pos_mod u_pos_mod (
      .clock, .reset, .adv,
      .period     (period_eff),
      .in_valid   (req_valid),
      .in_elapsed (req_elapsed_time_ms),
      .out_valid  (pos_v),
      .out_pos    (pos)
   );

   dnci_prog_div u_prog_div (
      .clock, .reset, .adv,
      .period       (period_eff),
      .in_valid     (pos_v),
      .in_pos       (pos),
      .out_valid    (prog_v),
      .out_progress (progress)
   );

   dnci_seg_frac u_seg_frac (
      .clock, .reset, .adv,
      .in_valid    (prog_v),
      .in_progress (progress),
      .out_valid   (frac_v),
      .out_seg     (seg),
      .out_frac    (frac)
   );

   dnci_blend u_blend (
      .clock, .reset, .adv,
      .master     (master_ff),
      .in_valid   (frac_v),
      .in_seg     (seg),
      .in_frac    (frac),
      .out_valid  (p_v),
      .out_red    (p_red),
      .out_green  (p_green),
      .out_blue   (p_blue),
      .out_bright (p_bright)
   );

   // output register with one skid entry behind it
   logic       out_v_ff;
   logic [7:0] out_r_ff, out_g_ff, out_b_ff, out_br_ff;
   logic [7:0] skid_r_ff, skid_g_ff, skid_b_ff, skid_br_ff;
   logic       out_take;

   assign out_take = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_take) begin
         out_v_ff  <= skid_v_ff || p_v;
         skid_v_ff <= 1'b0;
      end else if (p_v && adv) begin
         skid_v_ff <= 1'b1;
      end
      if (out_take) begin
         if (skid_v_ff) begin
            out_r_ff  <= skid_r_ff;
            out_g_ff  <= skid_g_ff;
            out_b_ff  <= skid_b_ff;
            out_br_ff <= skid_br_ff;
         end else begin
            out_r_ff  <= p_red;
            out_g_ff  <= p_green;
            out_b_ff  <= p_blue;
            out_br_ff <= p_bright;
         end
      end else if (adv) begin
         skid_r_ff  <= p_red;
         skid_g_ff  <= p_green;
         skid_b_ff  <= p_blue;
         skid_br_ff <= p_bright;
      end
   end

   assign rsp_valid                = out_v_ff;
   assign rsp_red_level            = out_r_ff;
   assign rsp_green_level          = out_g_ff;
   assign rsp_blue_level           = out_b_ff;
   assign rsp_effective_brightness = out_br_ff;

   // skid only ever holds behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid full while output empty");

   // skid fills only when the output was held
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall))
      else $error("skid filled without a held output");

   // a draining skid moves into the output and frees the pipe
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_stall) |=> (out_v_ff && !skid_v_ff))
      else $error("skid did not drain");
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the day/night color interpolator: each accepted
// timestamp is turned into the expected color and brightness by an
// independent model and compared in order with the block's output
// ---------------------------------------------------------------------------

typedef struct packed {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] bright;
} color_type;

class color_scoreboard;
   logic [26:0] period;
   logic [7:0]  master;
   color_type   expected_colors[$];
   int          errors;

   function void reset_regs();
      period = dnci_pkg::PERIOD_RESET;
      master = dnci_pkg::BRIGHTNESS_RESET;
   endfunction

   // linear step with signed truncation toward zero
   function logic [7:0] blend(int from, int to, int frac);
      int delta;
      delta = ((to - from) * frac) / 256;
      return 8'(from + delta);
   endfunction

   function void note(logic [31:0] elapsed);
      longint unsigned per, pos;
      int              progress, seg, frac, span, pct;
      color_type       c;
      per = (period == 0) ? 1 : period;
      pos = elapsed % per;
      progress = int'((pos * 65536) / per);
      seg = dnci_pkg::WP_COUNT - 2;
      for (int i = 1; i < dnci_pkg::WP_COUNT - 1; i++) begin
         if (progress < dnci_pkg::WP_POS[i]) begin
            seg = i - 1;
            break;
         end
      end
      span = dnci_pkg::WP_POS[seg+1] - dnci_pkg::WP_POS[seg];
      frac = ((progress - dnci_pkg::WP_POS[seg]) * 256) / span;
      c.red   = blend(dnci_pkg::WP_RED[seg], dnci_pkg::WP_RED[seg+1], frac);
      c.green = blend(dnci_pkg::WP_GREEN[seg], dnci_pkg::WP_GREEN[seg+1], frac);
      c.blue  = blend(dnci_pkg::WP_BLUE[seg], dnci_pkg::WP_BLUE[seg+1], frac);
      pct     = blend(dnci_pkg::WP_PCT[seg], dnci_pkg::WP_PCT[seg+1], frac);
      c.bright = 8'((int'(master) * pct) / 100);
      expected_colors.push_back(c);
   endfunction

   function void check(color_type got);
      color_type want;
      if (expected_colors.size() == 0) begin
         $display("%0t: unexpected transaction, actual %h", $time, got);
         errors++;
         return;
      end
      want = expected_colors.pop_front();
      if (got.red != want.red) begin
         $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
         errors++;
      end
      if (got.green != want.green) begin
         $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
         errors++;
      end
      if (got.blue != want.blue) begin
         $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
         errors++;
      end
      if (got.bright != want.bright) begin
         $display("%0t: brightness expected %0d actual %0d", $time, want.bright,
                  got.bright);
         errors++;
      end
   endfunction
endclass

module tb;
   import dnci_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_elapsed_time_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_level, rsp_green_level, rsp_blue_level;
   logic [7:0]  rsp_effective_brightness;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_CYCLE_PERIOD;
   logic [26:0] csr_data = '0;

   color_scoreboard sb = new();

   // receiver stall control
   int stall_mode = 0;
   int hold_cycles = 0;

   day_night_color_interpolator_top i_dut (.*);

   always #1 clock = ~clock;

   // receiver: long hold-off when asked, otherwise a pattern that changes mode
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // output monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check({rsp_red_level, rsp_green_level, rsp_blue_level,
                   rsp_effective_brightness});
   end

   // one input transaction; valid stays high unless an idle follows
   task automatic send_time(logic [31:0] t);
      @(negedge clock);
      req_valid <= 1'b1;
      req_elapsed_time_ms <= t;
      do @(posedge clock); while (req_stall);
      sb.note(t);
   endtask

   task automatic idle(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // drain everything, then let the pipe settle before touching registers
   task automatic drain();
      idle(1);
      while (sb.expected_colors.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [26:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_CYCLE_PERIOD) sb.period = value;
      else sb.master = value[7:0];
   endtask

   // random timestamp, biased toward small values and near period edges
   function automatic logic [31:0] pick_time();
      logic [31:0] per;
      per = (sb.period == 0) ? 1 : sb.period;
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 200000);
         2: return per * $urandom_range(0, 40) + $urandom_range(0, 3) - 1;
         default: return $urandom_range(0, per - 1);
      endcase
   endfunction

   task automatic random_phase(int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         int burst;
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_time(pick_time());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
      end
   endtask

   initial begin
      sb.reset_regs();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values first, input extremes
      send_time(32'd0);
      send_time(32'hFFFF_FFFF);
      send_time(32'd59999);

      // period of 65536 makes progress equal to the time: hit waypoints
      drain();
      write_reg(CSR_CYCLE_PERIOD, 27'd65536);
      foreach (WP_POS[i]) begin
         send_time(WP_POS[i]);
         if (i > 0) send_time(WP_POS[i] - 1);
      end
      send_time(32'd60292);

      // zero period behaves as one, master brightness zero
      drain();
      write_reg(CSR_CYCLE_PERIOD, 27'd0);
      write_reg(CSR_MASTER_BRIGHTNESS, 27'd0);
      send_time(32'd12345);
      send_time(32'hFFFF_FFFF);

      // random phases over several settings
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0: write_reg(CSR_CYCLE_PERIOD, 27'h7FF_FFFF);
            1: write_reg(CSR_CYCLE_PERIOD, 27'd86400000);
            2: write_reg(CSR_CYCLE_PERIOD, 27'd1);
            3: write_reg(CSR_CYCLE_PERIOD, 27'd60000);
            4: write_reg(CSR_CYCLE_PERIOD, 27'd3);
            default: write_reg(CSR_CYCLE_PERIOD, 27'($urandom()));
         endcase
         write_reg(CSR_MASTER_BRIGHTNESS,
                   (phase == 0) ? 27'd255 : (phase == 1) ? 27'd0 : 27'($urandom()));
         stall_mode = phase % 4;
         // long hold-off with more transactions offered than the pipe holds
         if (phase == 2) hold_cycles = 200;
         random_phase((phase == 2) ? 110 : 52);
      end

      drain();
      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
